// ===== hdl/dual_monod_cell_kinetics_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual Monod kinetics core
// Expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef DUAL_MONOD_CELL_KINETICS_CORE_DEFINES_SVH
`define DUAL_MONOD_CELL_KINETICS_CORE_DEFINES_SVH

// same-cycle implication
`define DMCK_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define DMCK_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/dmck_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmck_pkg
// Shared constants and register codes of the dual Monod kinetics core.
// ----------------------------------------------------------------------------
package dmck_pkg;

  // quotient width of the yield divide; larger results clamp to all ones
  localparam int QUOT_BITS = 36;
  localparam int CFG_COUNT = 8;

  // oxygen demand per unit nitrogen, 4.57 as a ratio
  localparam int unsigned K_O2_NUM = 457;
  localparam int unsigned K_O2_DEN = 100;

  typedef enum logic [2:0] {
    CFG_REACTION_EN = 3'd0,
    CFG_GROWTH_EN   = 3'd1,
    CFG_MU_MAX      = 3'd2,
    CFG_K_NH4       = 3'd3,
    CFG_K_O2        = 3'd4,
    CFG_YIELD       = 3'd5,
    CFG_MAINT       = 3'd6,
    CFG_DECAY       = 3'd7
  } cfg_idx_t;

endpackage

// ===== hdl/dmck_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmck_in_if
// Cell item channel: concentrations, density, ghost flag and current rates.
// ----------------------------------------------------------------------------
interface dmck_in_if #(
  parameter int VW = 32
);
  logic                 valid;
  logic                 ready;
  logic [VW-1:0]        conc_nh4;
  logic [VW-1:0]        conc_o2;
  logic [VW-1:0]        density;
  logic                 is_ghost;
  logic signed [VW-1:0] reac_nh4_in;
  logic signed [VW-1:0] reac_o2_in;
  logic signed [VW-1:0] reac_no2_in;

  modport source (
    output valid, conc_nh4, conc_o2, density, is_ghost,
           reac_nh4_in, reac_o2_in, reac_no2_in,
    input  ready
  );
  modport sink (
    input  valid, conc_nh4, conc_o2, density, is_ghost,
           reac_nh4_in, reac_o2_in, reac_no2_in,
    output ready
  );
endinterface

// ===== hdl/dmck_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmck_out_if
// Result channel: updated rates and specific growth rate.
// ----------------------------------------------------------------------------
interface dmck_out_if #(
  parameter int VW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] reac_nh4_out;
  logic signed [VW-1:0] reac_o2_out;
  logic signed [VW-1:0] reac_no2_out;
  logic signed [VW-1:0] growth_rate;
  logic                 growth_valid;

  modport source (
    output valid, reac_nh4_out, reac_o2_out, reac_no2_out, growth_rate, growth_valid,
    input  ready
  );
  modport sink (
    input  valid, reac_nh4_out, reac_o2_out, reac_no2_out, growth_rate, growth_valid,
    output ready
  );
endinterface

// ===== hdl/dmck_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmck_div_cell
// One restoring divide step: shifts in a dividend bit, trial subtracts,
// and passes remainder, quotient and side data to the next cell.
// ----------------------------------------------------------------------------
module dmck_div_cell #(
  parameter int DVW = 33,
  parameter int NB  = 25,
  parameter int SW  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_in,
  input  logic [DVW-1:0] rem_in,
  input  logic [NB-1:0]  sh_in,
  input  logic [DVW-1:0] dvs_in,
  input  logic [SW-1:0]  side_in,
  output logic           v_out,
  output logic [DVW-1:0] rem_out,
  output logic [NB-1:0]  sh_out,
  output logic [DVW-1:0] dvs_out,
  output logic [SW-1:0]  side_out
);

  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           take;
  logic           v_r;
  logic [DVW-1:0] rem_r;
  logic [NB-1:0]  sh_r;
  logic [DVW-1:0] dvs_r;
  logic [SW-1:0]  side_r;

  assign trial = {rem_in, sh_in[NB-1]};
  assign take  = trial >= {1'b0, dvs_in};
  assign diff  = trial - {1'b0, dvs_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? diff[DVW-1:0] : trial[DVW-1:0];
      sh_r   <= {sh_in[NB-2:0], take};
      dvs_r  <= dvs_in;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign rem_out  = rem_r;
  assign sh_out   = sh_r;
  assign dvs_out  = dvs_r;
  assign side_out = side_r;

endmodule

// ===== hdl/dmck_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmck_divider
// Chain of divide cells, one quotient bit per cell, one operand per cycle while en is high.
// ----------------------------------------------------------------------------
module dmck_divider #(
  parameter int NB  = 25,
  parameter int DVW = 33,
  parameter int SW  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_in,
  input  logic [DVW-1:0] rem_in,
  input  logic [NB-1:0]  bits_in,
  input  logic [DVW-1:0] dvs_in,
  input  logic [SW-1:0]  side_in,
  output logic           v_out,
  output logic [NB-1:0]  quot_out,
  output logic [SW-1:0]  side_out
);

  logic           v_c    [NB+1];
  logic [DVW-1:0] rem_c  [NB+1];
  logic [NB-1:0]  sh_c   [NB+1];
  logic [DVW-1:0] dvs_c  [NB+1];
  logic [SW-1:0]  side_c [NB+1];

  assign v_c[0]    = v_in;
  assign rem_c[0]  = rem_in;
  assign sh_c[0]   = bits_in;
  assign dvs_c[0]  = dvs_in;
  assign side_c[0] = side_in;

  for (genvar k = 0; k < NB; k++) begin : g_step
    dmck_div_cell #(
      .DVW (DVW),
      .NB  (NB),
      .SW  (SW)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (v_c[k]),
      .rem_in   (rem_c[k]),
      .sh_in    (sh_c[k]),
      .dvs_in   (dvs_c[k]),
      .side_in  (side_c[k]),
      .v_out    (v_c[k+1]),
      .rem_out  (rem_c[k+1]),
      .sh_out   (sh_c[k+1]),
      .dvs_out  (dvs_c[k+1]),
      .side_out (side_c[k+1])
    );
  end

  assign v_out    = v_c[NB];
  assign quot_out = sh_c[NB];
  assign side_out = side_c[NB];

endmodule

// ===== hdl/dual_monod_cell_kinetics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_monod_cell_kinetics_core
// Dual-substrate Monod uptake, maintenance and reaction rate update per cell.
//
//   channel   dir  handshake       beat
//   in_if     in   valid/ready     one grid cell
//   out_if    out  valid/ready     updated rates and growth rate
//   apb       in   psel/penable    one register write or read
//
// One beat per cycle when out_if does not stall. Each beat passes the Monod fraction
// divide cells, stages A, B and C, the yield divide cells, stage E and the registered
// output stage, in that order.
// Reset is synchronous; registers return to their listed defaults.
// A stall on out_if freezes the whole chain; in_if.ready follows it.
// ----------------------------------------------------------------------------
`include "dual_monod_cell_kinetics_core_defines.svh"

module dual_monod_cell_kinetics_core #(
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  dmck_in_if.sink                               in_if,
  dmck_out_if.source                            out_if,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [((VALUE_WIDTH > 32) ? 6 : 5)-1:0] paddr,
  input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                  pready
);

  localparam int VW   = VALUE_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int QB   = dmck_pkg::QUOT_BITS;
  localparam int PDW  = (VW > 32) ? 64 : 32;
  localparam int ASH  = (VW > 32) ? 3 : 2;
  localparam int AW   = ASH + 3;
  localparam int FW   = F + 1;
  localparam int S1W  = VW + 1;
  localparam int PW   = 2 * VW;
  localparam int KW   = F + 3;
  localparam int GW   = KW + QB;
  localparam int SUMW = ((PW > GW) ? PW : GW) + 4;
  localparam int SD1W = 4 * VW + 2;
  localparam int SD2W = 2 * PW + 4 * VW + 3;

  localparam logic [63:0] K_O2_FULL =
    ((64'(dmck_pkg::K_O2_NUM) << F) + 64'(dmck_pkg::K_O2_DEN / 2)) /
    64'(dmck_pkg::K_O2_DEN);
  localparam logic [KW-1:0] K_O2 = K_O2_FULL[KW-1:0];
  localparam logic [QB-1:0] QCAP = {QB{1'b1}};
  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [VW-1:0] sat_val(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[VW-1:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic          reac_en_r, grow_en_r;
  logic [VW-1:0] mu_r, kn_r, ko_r, yld_r, maint_r, decay_r;
  logic          cfg_wr;
  dmck_pkg::cfg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dmck_pkg::cfg_idx_t'(paddr[AW-1:ASH]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reac_en_r <= 1'b1;
      grow_en_r <= 1'b1;
      mu_r      <= '0;
      kn_r      <= VW'(1) << F;
      ko_r      <= VW'(1) << F;
      yld_r     <= VW'(1) << F;
      maint_r   <= '0;
      decay_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dmck_pkg::CFG_REACTION_EN: reac_en_r <= pwdata[0];
        dmck_pkg::CFG_GROWTH_EN:   grow_en_r <= pwdata[0];
        dmck_pkg::CFG_MU_MAX:      mu_r      <= pwdata[VW-1:0];
        dmck_pkg::CFG_K_NH4:       kn_r      <= pwdata[VW-1:0];
        dmck_pkg::CFG_K_O2:        ko_r      <= pwdata[VW-1:0];
        dmck_pkg::CFG_YIELD:       yld_r     <= pwdata[VW-1:0];
        dmck_pkg::CFG_MAINT:       maint_r   <= pwdata[VW-1:0];
        dmck_pkg::CFG_DECAY:       decay_r   <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dmck_pkg::CFG_REACTION_EN: prdata = PDW'(reac_en_r);
      dmck_pkg::CFG_GROWTH_EN:   prdata = PDW'(grow_en_r);
      dmck_pkg::CFG_MU_MAX:      prdata = PDW'(mu_r);
      dmck_pkg::CFG_K_NH4:       prdata = PDW'(kn_r);
      dmck_pkg::CFG_K_O2:        prdata = PDW'(ko_r);
      dmck_pkg::CFG_YIELD:       prdata = PDW'(yld_r);
      dmck_pkg::CFG_MAINT:       prdata = PDW'(maint_r);
      dmck_pkg::CFG_DECAY:       prdata = PDW'(decay_r);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic out_v_r;
  logic pipe_en;

  assign pipe_en     = !out_v_r || out_if.ready;
  assign in_if.ready = pipe_en;

  // ---------------- Monod fractions ----------------
  logic [S1W-1:0]  sn, so;
  logic            zn, zo;
  logic            d1_v, d1o_v;
  logic [FW-1:0]   qn, qo;
  logic [SD1W-1:0] side1_in, side1_out;
  logic            zo_out;

  assign sn = {1'b0, in_if.conc_nh4} + {1'b0, kn_r};
  assign so = {1'b0, in_if.conc_o2} + {1'b0, ko_r};
  assign zn = (sn == '0);
  assign zo = (so == '0);
  assign side1_in = {in_if.density, in_if.is_ghost, in_if.reac_nh4_in,
                     in_if.reac_o2_in, in_if.reac_no2_in, zn};

  dmck_divider #(.NB(FW), .DVW(S1W), .SW(SD1W)) u_div_nh4 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .v_in     (in_if.valid),
    .rem_in   (S1W'(in_if.conc_nh4 >> 1)),
    .bits_in  ({in_if.conc_nh4[0], {F{1'b0}}}),
    .dvs_in   (sn),
    .side_in  (side1_in),
    .v_out    (d1_v),
    .quot_out (qn),
    .side_out (side1_out)
  );

  dmck_divider #(.NB(FW), .DVW(S1W), .SW(1)) u_div_o2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .v_in     (in_if.valid),
    .rem_in   (S1W'(in_if.conc_o2 >> 1)),
    .bits_in  ({in_if.conc_o2[0], {F{1'b0}}}),
    .dvs_in   (so),
    .side_in  (zo),
    .v_out    (d1o_v),
    .quot_out (qo),
    .side_out (zo_out)
  );

  logic [VW-1:0]        rho_d;
  logic                 ghost_d;
  logic signed [VW-1:0] rn_d, ro_d, rq_d;
  logic                 zn_d;
  logic [FW-1:0]        fn, fo;

  assign {rho_d, ghost_d, rn_d, ro_d, rq_d, zn_d} = side1_out;
  // empty affinity sum reads as zero fraction
  assign fn = zn_d   ? '0 : qn;
  assign fo = zo_out ? '0 : qo;

  // ---------------- stage A: mu*fn, maint*fo ----------------
  logic [VW+FW-1:0]     mfn, mfo;
  logic                 a_v_r;
  logic [VW-1:0]        a_r, mt_a_r, rho_a_r;
  logic [FW-1:0]        fo_a_r;
  logic                 upd_a_r;
  logic signed [VW-1:0] rn_a_r, ro_a_r, rq_a_r;

  assign mfn = {{FW{1'b0}}, mu_r} * {{VW{1'b0}}, fn};
  assign mfo = {{FW{1'b0}}, maint_r} * {{VW{1'b0}}, fo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (pipe_en) begin
      a_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_r     <= mfn[F +: VW];
      mt_a_r  <= mfo[F +: VW];
      fo_a_r  <= fo;
      rho_a_r <= rho_d;
      upd_a_r <= reac_en_r && !ghost_d;
      rn_a_r  <= rn_d;
      ro_a_r  <= ro_d;
      rq_a_r  <= rq_d;
    end
  end

  // ---------------- stage B: uptake ----------------
  logic [VW+FW-1:0]     afo;
  logic                 b_v_r;
  logic [VW-1:0]        up_b_r, mt_b_r, rho_b_r;
  logic                 upd_b_r;
  logic signed [VW-1:0] rn_b_r, ro_b_r, rq_b_r;

  assign afo = {{FW{1'b0}}, a_r} * {{VW{1'b0}}, fo_a_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (pipe_en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      up_b_r  <= afo[F +: VW];
      mt_b_r  <= mt_a_r;
      rho_b_r <= rho_a_r;
      upd_b_r <= upd_a_r;
      rn_b_r  <= rn_a_r;
      ro_b_r  <= ro_a_r;
      rq_b_r  <= rq_a_r;
    end
  end

  // ---------------- stage C: density products, growth ----------------
  logic signed [SUMW-1:0] grow_sum;
  logic                   c_v_r;
  logic [PW-1:0]          p_c_r, mdp_c_r;
  logic [VW-1:0]          grow_c_r;
  logic                   gv_c_r, upd_c_r;
  logic signed [VW-1:0]   rn_c_r, ro_c_r, rq_c_r;

  assign grow_sum = SUMW'(up_b_r) - SUMW'(mt_b_r) - SUMW'(decay_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (pipe_en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p_c_r    <= {{VW{1'b0}}, up_b_r} * {{VW{1'b0}}, rho_b_r};
      mdp_c_r  <= {{VW{1'b0}}, mt_b_r} * {{VW{1'b0}}, rho_b_r};
      grow_c_r <= grow_en_r ? sat_val(grow_sum) : '0;
      gv_c_r   <= grow_en_r;
      upd_c_r  <= upd_b_r;
      rn_c_r   <= rn_b_r;
      ro_c_r   <= ro_b_r;
      rq_c_r   <= rq_b_r;
    end
  end

  // ---------------- yield divide ----------------
  logic [PW+QB-1:0] pext, ylim;
  logic             qsat;
  logic [PW-1:0]    x_c, md_c;
  logic [SD2W-1:0]  side2_in, side2_out;
  logic             d2_v;
  logic [QB-1:0]    quot2;

  assign pext = {{QB{1'b0}}, p_c_r};
  assign ylim = (PW+QB)'({yld_r, {QB{1'b0}}});
  // quotient beyond the clamp, or zero yield
  assign qsat = pext >= ylim;
  assign x_c  = p_c_r >> F;
  assign md_c = mdp_c_r >> F;
  assign side2_in = {x_c, md_c, rn_c_r, ro_c_r, rq_c_r, grow_c_r, gv_c_r, upd_c_r, qsat};

  dmck_divider #(.NB(QB), .DVW(VW), .SW(SD2W)) u_div_yield (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .v_in     (c_v_r),
    .rem_in   (pext[QB +: VW]),
    .bits_in  (pext[QB-1:0]),
    .dvs_in   (yld_r),
    .side_in  (side2_in),
    .v_out    (d2_v),
    .quot_out (quot2),
    .side_out (side2_out)
  );

  logic [PW-1:0]        x_d, md_d;
  logic signed [VW-1:0] rn_d2, ro_d2, rq_d2;
  logic [VW-1:0]        grow_d;
  logic                 gv_d, upd_d, qsat_d;
  logic [QB-1:0]        q_d;

  assign {x_d, md_d, rn_d2, ro_d2, rq_d2, grow_d, gv_d, upd_d, qsat_d} = side2_out;
  assign q_d = qsat_d ? QCAP : quot2;

  // ---------------- stage E: oxygen demand ----------------
  logic                 e_v_r;
  logic [GW-1:0]        g_e_r;
  logic [QB-1:0]        q_e_r;
  logic [PW-1:0]        x_e_r, md_e_r;
  logic signed [VW-1:0] rn_e_r, ro_e_r, rq_e_r;
  logic [VW-1:0]        grow_e_r;
  logic                 gv_e_r, upd_e_r;
  logic [GW-1:0]        kq;

  assign kq = {{QB{1'b0}}, K_O2} * {{KW{1'b0}}, q_d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (pipe_en) begin
      e_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      g_e_r    <= kq >> F;
      q_e_r    <= q_d;
      x_e_r    <= x_d;
      md_e_r   <= md_d;
      rn_e_r   <= rn_d2;
      ro_e_r   <= ro_d2;
      rq_e_r   <= rq_d2;
      grow_e_r <= grow_d;
      gv_e_r   <= gv_d;
      upd_e_r  <= upd_d;
    end
  end

  // ---------------- output stage: sums and clamp ----------------
  logic signed [SUMW-1:0] dq, dox, nh4_sum, o2_sum, no2_sum;
  logic [VW-1:0]          nh4_r, o2_r, no2_r, grow_r;
  logic                   gv_r;

  // reaction off or ghost cell: no delta
  assign dq      = upd_e_r ? SUMW'(q_e_r) : '0;
  assign dox     = upd_e_r ? (SUMW'(g_e_r) - SUMW'(x_e_r) + SUMW'(md_e_r)) : '0;
  assign nh4_sum = SUMW'(rn_e_r) - dq;
  assign no2_sum = SUMW'(rq_e_r) + dq;
  assign o2_sum  = SUMW'(ro_e_r) - dox;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pipe_en) begin
      out_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      nh4_r  <= sat_val(nh4_sum);
      o2_r   <= sat_val(o2_sum);
      no2_r  <= sat_val(no2_sum);
      grow_r <= grow_e_r;
      gv_r   <= gv_e_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.reac_nh4_out = nh4_r;
  assign out_if.reac_o2_out  = o2_r;
  assign out_if.reac_no2_out = no2_r;
  assign out_if.growth_rate  = grow_r;
  assign out_if.growth_valid = gv_r;

  // ---------------- assertions ----------------
  `DMCK_ASSERT_IMP(a_div_lockstep, 1'b1, d1_v == d1o_v, "fraction dividers out of step")
  `DMCK_ASSERT_IMP(a_frac_bound, d1_v && !zn_d, qn <= {1'b1, {F{1'b0}}}, "fraction above one")
  `DMCK_ASSERT_IMP(a_growth_off, out_v_r && !gv_r, grow_r == '0, "growth rate set while off")
  `DMCK_ASSERT_NXT(a_tail_advance, pipe_en && e_v_r, out_v_r, "beat lost before output")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual Monod kinetics core. Cells stream in over
// the input channel under random stalls, a local fixed-point predictor works
// out each cell's rates and growth, and every result beat is checked in order.
// The register set is reprogrammed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FB = 24;
  localparam int VW = 32;
  localparam int DRAIN_CYCLES = 70;
  localparam int HANG_LIMIT = 5000;
  localparam longint unsigned QMAX = (64'd1 << dmck_pkg::QUOT_BITS) - 64'd1;
  localparam longint unsigned K_O2 =
    ((longint'(dmck_pkg::K_O2_NUM) << FB) + longint'(dmck_pkg::K_O2_DEN / 2)) /
    longint'(dmck_pkg::K_O2_DEN);

  typedef struct {
    logic [VW-1:0]        conc_nh4;
    logic [VW-1:0]        conc_o2;
    logic [VW-1:0]        density;
    logic                 is_ghost;
    logic signed [VW-1:0] rate_nh4;
    logic signed [VW-1:0] rate_o2;
    logic signed [VW-1:0] rate_no2;
  } cell_t;

  typedef struct {
    logic signed [VW-1:0] rate_nh4;
    logic signed [VW-1:0] rate_o2;
    logic signed [VW-1:0] rate_no2;
    logic signed [VW-1:0] growth;
    logic                 growth_ok;
  } rates_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dmck_in_if  #(.VW(VW)) in_if ();
  dmck_out_if #(.VW(VW)) out_if ();

  dual_monod_cell_kinetics_core #(.FRAC_BITS(FB), .VALUE_WIDTH(VW)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // local copy of the register set
  bit reac_en = 1'b1, grow_en = 1'b1;
  longint unsigned mu_max = 0, k_nh4 = 64'd1 << FB, k_o2 = 64'd1 << FB;
  longint unsigned yield_c = 64'd1 << FB, maint = 0, decay = 0;

  cell_t  cells_to_send[$];
  rates_t rates_due[$];
  int n_sent = 0, n_checked = 0, n_errors = 0, n_phases = 0;
  bit no_gaps = 1'b0;
  int idle_cnt = 0;

  function automatic longint unsigned monod_frac(longint unsigned c, longint unsigned k);
    longint unsigned s;
    s = c + k;
    return (s == 0) ? 64'd0 : (c << FB) / s;
  endfunction

  function automatic logic signed [VW-1:0] clamp_rate(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[VW-1:0];
  endfunction

  function automatic rates_t kinetics(cell_t c);
    longint unsigned fn, fo, up, mt, p, x, md, q, g;
    longint rn, ro, rq;
    rates_t r;
    fn = monod_frac(64'(c.conc_nh4), k_nh4);
    fo = monod_frac(64'(c.conc_o2), k_o2);
    up = (((mu_max * fn) >> FB) * fo) >> FB;
    mt = (maint * fo) >> FB;
    rn = c.rate_nh4;
    ro = c.rate_o2;
    rq = c.rate_no2;
    if (reac_en && !c.is_ghost) begin
      p  = up * 64'(c.density);
      x  = p >> FB;
      md = (mt * 64'(c.density)) >> FB;
      q  = (yield_c != 0) ? p / yield_c : QMAX;
      if (q > QMAX) q = QMAX;
      g  = (K_O2 * q) >> FB;
      rn = rn - longint'(q);
      rq = rq + longint'(q);
      ro = ro - (longint'(g) - longint'(x) + longint'(md));
    end
    r.rate_nh4 = clamp_rate(rn);
    r.rate_o2  = clamp_rate(ro);
    r.rate_no2 = clamp_rate(rq);
    if (grow_en) begin
      r.growth = clamp_rate(longint'(up) - longint'(mt) - longint'(decay));
      r.growth_ok = 1'b1;
    end else begin
      r.growth = '0;
      r.growth_ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h01000000;
      3: return $urandom_range(0, 32'h04000000);
      4: return $urandom_range(0, 255) << $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    c.conc_nh4 = pick_value();
    c.conc_o2  = pick_value();
    c.density  = pick_value();
    c.is_ghost = ($urandom_range(0, 5) == 0);
    c.rate_nh4 = ($urandom_range(0, 7) == 0) ? 32'h7fffffff : pick_value();
    c.rate_o2  = ($urandom_range(0, 7) == 0) ? 32'h80000000 : pick_value();
    c.rate_no2 = ($urandom_range(0, 7) == 0) ? 32'h7fffffff : pick_value();
    return c;
  endfunction

  function automatic cell_t make_cell(logic [31:0] cn, logic [31:0] co, logic [31:0] rho,
                                      logic gh, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] d);
    cell_t c;
    c.conc_nh4 = cn; c.conc_o2 = co; c.density = rho; c.is_ghost = gh;
    c.rate_nh4 = a; c.rate_o2 = b; c.rate_no2 = d;
    return c;
  endfunction

  task automatic apb_write(dmck_pkg::cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      dmck_pkg::CFG_REACTION_EN: reac_en = v[0];
      dmck_pkg::CFG_GROWTH_EN:   grow_en = v[0];
      dmck_pkg::CFG_MU_MAX:      mu_max  = 64'(v);
      dmck_pkg::CFG_K_NH4:       k_nh4   = 64'(v);
      dmck_pkg::CFG_K_O2:        k_o2    = 64'(v);
      dmck_pkg::CFG_YIELD:       yield_c = 64'(v);
      dmck_pkg::CFG_MAINT:       maint   = 64'(v);
      dmck_pkg::CFG_DECAY:       decay   = 64'(v);
      default: ;
    endcase
  endtask

  task automatic program_all(logic re, logic ge, logic [31:0] mu, logic [31:0] kn,
                             logic [31:0] ko, logic [31:0] y, logic [31:0] mn,
                             logic [31:0] dc);
    apb_write(dmck_pkg::CFG_REACTION_EN, {31'd0, re});
    apb_write(dmck_pkg::CFG_GROWTH_EN, {31'd0, ge});
    apb_write(dmck_pkg::CFG_MU_MAX, mu);
    apb_write(dmck_pkg::CFG_K_NH4, kn);
    apb_write(dmck_pkg::CFG_K_O2, ko);
    apb_write(dmck_pkg::CFG_YIELD, y);
    apb_write(dmck_pkg::CFG_MAINT, mn);
    apb_write(dmck_pkg::CFG_DECAY, dc);
  endtask

  // wait for every queued cell to be sent and answered, then let the chain empty
  task automatic settle();
    while (cells_to_send.size() != 0 || rates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.conc_nh4 <= '0; in_if.conc_o2 <= '0; in_if.density <= '0;
      in_if.is_ghost <= 1'b0;
      in_if.reac_nh4_in <= '0; in_if.reac_o2_in <= '0; in_if.reac_no2_in <= '0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_if.valid && in_if.ready) begin
        rates_due.push_back(kinetics(cells_to_send[0]));
        void'(cells_to_send.pop_front());
        n_sent++;
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (cells_to_send.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 15);
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid       <= 1'b1;
        in_if.conc_nh4    <= cells_to_send[0].conc_nh4;
        in_if.conc_o2     <= cells_to_send[0].conc_o2;
        in_if.density     <= cells_to_send[0].density;
        in_if.is_ghost    <= cells_to_send[0].is_ghost;
        in_if.reac_nh4_in <= cells_to_send[0].rate_nh4;
        in_if.reac_o2_in  <= cells_to_send[0].rate_o2;
        in_if.reac_no2_in <= cells_to_send[0].rate_no2;
      end
    end
  end

  // result monitor with random back-pressure
  int out_stall = 0;
  always @(posedge clk) begin
    rates_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_checked++;
        if (rates_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got nh4 %h", $time,
                   out_if.reac_nh4_out);
          n_errors++;
        end else begin
          e = rates_due.pop_front();
          if (out_if.reac_nh4_out !== e.rate_nh4) begin
            $display("%0t: reac_nh4_out expected %h actual %h", $time, e.rate_nh4,
                     out_if.reac_nh4_out);
            n_errors++;
          end
          if (out_if.reac_o2_out !== e.rate_o2) begin
            $display("%0t: reac_o2_out expected %h actual %h", $time, e.rate_o2,
                     out_if.reac_o2_out);
            n_errors++;
          end
          if (out_if.reac_no2_out !== e.rate_no2) begin
            $display("%0t: reac_no2_out expected %h actual %h", $time, e.rate_no2,
                     out_if.reac_no2_out);
            n_errors++;
          end
          if (out_if.growth_rate !== e.growth) begin
            $display("%0t: growth_rate expected %h actual %h", $time, e.growth,
                     out_if.growth_rate);
            n_errors++;
          end
          if (out_if.growth_valid !== e.growth_ok) begin
            $display("%0t: growth_valid expected %b actual %b", $time, e.growth_ok,
                     out_if.growth_valid);
            n_errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_if.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        out_stall <= $urandom_range(0, 15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles with no beat on either channel or the register port
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: zero uptake, pass-through of rates
    cells_to_send.push_back(make_cell(32'h01000000, 32'h01000000, 32'h01000000, 1'b0,
                                      32'h00100000, 32'hfff00000, 32'h00000010));
    cells_to_send.push_back(make_cell(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0,
                                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    settle();
    n_phases++;

    // directed: moderate constants, field extremes, ghost and empty cells
    program_all(1'b1, 1'b1, 32'h01800000, 32'h00800000, 32'h00400000, 32'h00666666,
                32'h0019999a, 32'h000ccccd);
    cells_to_send.push_back(make_cell(0, 0, 0, 1'b0, 0, 0, 0));
    cells_to_send.push_back(make_cell(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0,
                                      32'h80000000, 32'h7fffffff, 32'h7fffffff));
    cells_to_send.push_back(make_cell(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
                                      32'h80000000, 32'h7fffffff, 32'h7fffffff));
    cells_to_send.push_back(make_cell(32'h02000000, 32'h00000000, 32'h05000000, 1'b0,
                                      32'h12345678, 32'hedcba987, 32'h00000001));
    cells_to_send.push_back(make_cell(32'h00000000, 32'h03000000, 32'h05000000, 1'b0,
                                      32'hffffffff, 32'h00000000, 32'h80000000));
    cells_to_send.push_back(make_cell(32'h10000000, 32'h08000000, 32'h40000000, 1'b0,
                                      32'h00000000, 32'h00000000, 32'h00000000));
    cells_to_send.push_back(make_cell(32'h00000001, 32'h00000001, 32'h00000001, 1'b0,
                                      32'h00000001, 32'hffffffff, 32'hfffffffe));
    cells_to_send.push_back(make_cell(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b1,
                                      32'h55555555, 32'haaaaaaaa, 32'h55555555));
    settle();
    n_phases++;

    // empty affinity sum, zero yield, all enables off
    program_all(1'b0, 1'b0, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff);
    cells_to_send.push_back(make_cell(0, 0, 32'hffffffff, 1'b0, 32'h7fffffff, 0, 0));
    cells_to_send.push_back(make_cell(32'h01000000, 32'h01000000, 1, 1'b0, 1, 2, 3));
    // let the chain empty before the enables change
    settle();
    apb_write(dmck_pkg::CFG_REACTION_EN, 32'd1);
    apb_write(dmck_pkg::CFG_GROWTH_EN, 32'd1);
    cells_to_send.push_back(make_cell(0, 0, 32'hffffffff, 1'b0, 32'h7fffffff, 0, 0));
    cells_to_send.push_back(make_cell(32'h01000000, 32'h01000000, 32'h01000000, 1'b0,
                                      0, 0, 0));
    cells_to_send.push_back(make_cell(32'hffffffff, 0, 32'hffffffff, 1'b0,
                                      32'h80000000, 32'h80000000, 32'h7fffffff));
    settle();
    n_phases++;

    // random phases; registers swept through extremes and random values
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: program_all(1'b1, 1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 32'hffffffff);
        1: program_all(1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
        2: program_all(1'b1, 1'b0, 32'hffffffff, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
        3: program_all(1'b0, 1'b1, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
        default: program_all(($urandom_range(0, 4) != 0), ($urandom_range(0, 4) != 0),
                             pick_value(), pick_value(), pick_value(),
                             pick_value() | 32'h1, pick_value(), pick_value());
      endcase
      no_gaps = (ph == 10);
      cells_to_send.push_back(make_cell(0, 0, $urandom, 1'b0, $urandom, $urandom, $urandom));
      for (int i = 0; i < 149; i++) cells_to_send.push_back(random_cell());
      settle();
      n_phases++;
    end

    $display("Checked %0d results from %0d cells over %0d register settings.",
             n_checked, n_sent, n_phases);
    $display("Covered ghost and reactive cells, saturating sums, enables and zero yield.");
    if (n_errors == 0 && rates_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
